@@ hw/rtl/kufe_pkg.sv @@
// Shared constants, types and codes for the union-find spanning-tree engine.
package kufe_pkg;

	// Largest node number the tables hold; entry 0 is kept but never used by an edge.
	localparam int NODE_LIMIT  = 511;
	localparam int TABLE_DEPTH = NODE_LIMIT + 1;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = IDX_W + 1;
	localparam int SETS_W      = IDX_W + 1;

	// Fixed port widths.
	localparam int NODE_W   = 9;
	localparam int WEIGHT_W = 16;
	localparam int SUM_W    = 25;
	localparam int COUNT_W  = 9;

	localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Command codes.
	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_EDGE  = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK_A,
		ST_WALK_B
	} state_t;

endpackage

@@ hw/rtl/kruskal_union_find_engine_unit.sv @@
// Top level of the union-find spanning-tree engine: control, root walks and linking.
//
// Kruskal spanning-tree engine over a disjoint-set table held in two RAMs (parent and set
// size, one entry per node). Issue a command by raising start while busy is low; the item
// is taken at that clock edge. Exactly one result follows for every item: done is high for
// a single cycle and accepted, total_weight, component_count and all_joined are valid in
// that cycle. The receiver cannot hold a result off, so sample it when done is high.
// Timing: an edge with an endpoint out of range, or offered once one set or fewer remain,
// reports in the cycle after it is taken. A valid edge walks to the root of node_a, then
// to the root of node_b, one parent read per cycle through the RAM's registered read port,
// and reports after it has found both roots. Union by size keeps the number of links from
// a node up to its root at or below log2 of the set size. A clear, and the pass that
// follows reset, rewrites every table entry, one per cycle, with busy high; a clear
// reports in the cycle after its pass ends, the reset pass reports nothing.
// Sequence edges in ascending weight for a minimum spanning forest; the order is not
// checked. The node-count register may be written whenever the engine is idle: the
// range check on edges uses it at once, the component count picks it up at the next clear.
module kruskal_union_find_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration
	input  logic                          cfg_we,
	input  logic [kufe_pkg::NODE_W-1:0]   cfg_wdata,
	// Command channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [kufe_pkg::NODE_W-1:0]   node_a,
	input  logic [kufe_pkg::NODE_W-1:0]   node_b,
	input  logic [kufe_pkg::WEIGHT_W-1:0] weight,
	// Result channel
	output logic                          done,
	output logic                          accepted,
	output logic [kufe_pkg::SUM_W-1:0]    total_weight,
	output logic [kufe_pkg::COUNT_W-1:0]  component_count,
	output logic                          all_joined
);

	localparam int IDX_W  = kufe_pkg::IDX_W;
	localparam int SIZE_W = kufe_pkg::SIZE_W;
	localparam int SETS_W = kufe_pkg::SETS_W;
	localparam int SUM_W  = kufe_pkg::SUM_W;

	kufe_pkg::state_t state_q, state_d;

	logic [kufe_pkg::NODE_W-1:0]   nodes_used_q;
	logic [SETS_W-1:0]             sets_left_q;
	logic [SUM_W-1:0]              weight_sum_q;
	logic [kufe_pkg::WEIGHT_W-1:0] weight_q;
	// node_b is held by the issuer only at the accepting edge, so keep a copy.
	logic [kufe_pkg::NODE_W-1:0]   node_b_q;
	logic [IDX_W-1:0]              cur_q;
	logic [IDX_W-1:0]              root_a_q;
	logic [SIZE_W-1:0]             size_a_q;
	logic [IDX_W-1:0]              clr_q;
	logic                          report_q;
	logic                          done_q;
	logic                          accepted_q;

	// RAM ports
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  par_rd;
	logic [SIZE_W-1:0] sz_rd;
	logic              par_we;
	logic [IDX_W-1:0]  par_waddr;
	logic [IDX_W-1:0]  par_wdata;
	logic              sz_we;
	logic [IDX_W-1:0]  sz_waddr;
	logic [SIZE_W-1:0] sz_wdata;

	// Decode
	logic [SETS_W-1:0] n_act;
	logic              a_ok;
	logic              b_ok;
	logic              edge_ok;
	logic              take;
	logic              hit;
	logic              differ;
	logic              a_bigger;
	logic              clr_last;
	logic [SIZE_W-1:0] size_sum;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_sat;

	// Parent pointers and set sizes; same read address, separate write addresses.
	kufe_ram #(
		.WIDTH(IDX_W),
		.DEPTH(kufe_pkg::TABLE_DEPTH)
	) u_parent_ram (
		.clk   (clk),
		.we    (par_we),
		.waddr (par_waddr),
		.wdata (par_wdata),
		.raddr (rd_addr),
		.rdata (par_rd)
	);

	kufe_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(kufe_pkg::TABLE_DEPTH)
	) u_size_ram (
		.clk   (clk),
		.we    (sz_we),
		.waddr (sz_waddr),
		.wdata (sz_wdata),
		.raddr (rd_addr),
		.rdata (sz_rd)
	);

	// Active node count, clamped to the largest node number.
	assign n_act = (32'(nodes_used_q) > kufe_pkg::NODE_LIMIT) ?
		SETS_W'(kufe_pkg::NODE_LIMIT) : SETS_W'(nodes_used_q);

	assign a_ok    = (node_a != '0) && (32'(node_a) <= 32'(n_act));
	assign b_ok    = (node_b != '0) && (32'(node_b) <= 32'(n_act));
	assign edge_ok = a_ok && b_ok && (sets_left_q > SETS_W'(1));
	assign take    = start && !busy;

	// In the walk states the read data belongs to the address issued last cycle, which is cur_q.
	assign hit      = (par_rd == cur_q);
	assign differ   = (root_a_q != cur_q);
	assign a_bigger = (size_a_q > sz_rd);
	assign size_sum = size_a_q + sz_rd;
	assign clr_last = (clr_q == IDX_W'(kufe_pkg::TABLE_DEPTH - 1));

	// Saturating weight total.
	assign sum_ext = {1'b0, weight_sum_q} + (SUM_W + 1)'(weight_q);
	assign sum_sat = sum_ext[SUM_W] ? kufe_pkg::SUM_MAX : sum_ext[SUM_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kufe_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = kufe_pkg::ST_IDLE;
				end
			end
			kufe_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd == kufe_pkg::CMD_CLEAR) begin
						state_d = kufe_pkg::ST_CLEAR;
					end else if (edge_ok) begin
						state_d = kufe_pkg::ST_WALK_A;
					end
				end
			end
			kufe_pkg::ST_WALK_A: begin
				if (hit) begin
					state_d = kufe_pkg::ST_WALK_B;
				end
			end
			kufe_pkg::ST_WALK_B: begin
				if (hit) begin
					state_d = kufe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kufe_pkg::ST_IDLE;
			end
		endcase
	end

	// RAM control. The link write lands at the edge that ends the walk; the next read is
	// issued no earlier than the following cycle, so no forwarding is needed.
	always_comb begin
		rd_addr   = cur_q;
		par_we    = 1'b0;
		par_waddr = cur_q;
		par_wdata = root_a_q;
		sz_we     = 1'b0;
		sz_waddr  = cur_q;
		sz_wdata  = size_sum;
		case (state_q)
			kufe_pkg::ST_CLEAR: begin
				par_we    = 1'b1;
				par_waddr = clr_q;
				par_wdata = clr_q;
				sz_we     = 1'b1;
				sz_waddr  = clr_q;
				sz_wdata  = SIZE_W'(1);
			end
			kufe_pkg::ST_IDLE: begin
				rd_addr = IDX_W'(node_a);
			end
			kufe_pkg::ST_WALK_A: begin
				rd_addr = hit ? IDX_W'(node_b_q) : par_rd;
			end
			kufe_pkg::ST_WALK_B: begin
				rd_addr = par_rd;
				if (hit && differ) begin
					par_we = 1'b1;
					sz_we  = 1'b1;
					if (a_bigger) begin
						// hang root b under root a
						par_waddr = cur_q;
						par_wdata = root_a_q;
						sz_waddr  = root_a_q;
					end else begin
						// tie or smaller: hang root a under root b
						par_waddr = root_a_q;
						par_wdata = cur_q;
						sz_waddr  = cur_q;
					end
				end
			end
			default: begin
				rd_addr = cur_q;
			end
		endcase
	end

	// Registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kufe_pkg::ST_CLEAR;
			nodes_used_q <= kufe_pkg::NODE_W'(511);
			sets_left_q  <= (kufe_pkg::NODE_LIMIT > 511) ? SETS_W'(511) :
				SETS_W'(kufe_pkg::NODE_LIMIT);
			weight_sum_q <= '0;
			clr_q        <= '0;
			report_q     <= 1'b0;
			done_q       <= 1'b0;
			accepted_q   <= 1'b0;
			weight_q     <= '0;
			node_b_q     <= '0;
			cur_q        <= '0;
			root_a_q     <= '0;
			size_a_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				nodes_used_q <= cfg_wdata;
			end
			case (state_q)
				kufe_pkg::ST_CLEAR: begin
					clr_q  <= clr_q + IDX_W'(1);
					// report a commanded clear, stay silent after reset
					done_q <= clr_last && report_q;
					if (clr_last) begin
						report_q <= 1'b0;
					end
				end
				kufe_pkg::ST_IDLE: begin
					// out of range or already joined: drop at once
					done_q <= take && (cmd == kufe_pkg::CMD_EDGE) && !edge_ok;
					if (take) begin
						weight_q <= weight;
						node_b_q <= node_b;
						if (cmd == kufe_pkg::CMD_CLEAR) begin
							clr_q        <= '0;
							report_q     <= 1'b1;
							sets_left_q  <= n_act;
							weight_sum_q <= '0;
							accepted_q   <= 1'b0;
						end else if (edge_ok) begin
							cur_q <= IDX_W'(node_a);
						end else begin
							accepted_q <= 1'b0;
						end
					end
				end
				kufe_pkg::ST_WALK_A: begin
					done_q <= 1'b0;
					if (hit) begin
						root_a_q <= cur_q;
						size_a_q <= sz_rd;
						cur_q    <= IDX_W'(node_b_q);
					end else begin
						cur_q <= par_rd;
					end
				end
				kufe_pkg::ST_WALK_B: begin
					done_q <= hit;
					if (hit) begin
						if (differ) begin
							accepted_q   <= 1'b1;
							sets_left_q  <= (sets_left_q != '0) ? sets_left_q - SETS_W'(1) : '0;
							weight_sum_q <= sum_sat;
						end else begin
							accepted_q <= 1'b0;
						end
					end else begin
						cur_q <= par_rd;
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Outputs
	assign busy            = (state_q != kufe_pkg::ST_IDLE);
	assign done            = done_q;
	assign accepted        = accepted_q;
	assign total_weight    = weight_sum_q;
	assign component_count = (32'(sets_left_q) > 32'(kufe_pkg::COUNT_MAX)) ?
		kufe_pkg::COUNT_MAX : kufe_pkg::COUNT_W'(sets_left_q);
	assign all_joined      = (sets_left_q == SETS_W'(1));

endmodule

@@ hw/rtl/kufe_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module kufe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ verif/kufe_result_checker.sv @@
// Result checker for the spanning-tree engine: forest predictor and in-order report compare.
module kufe_result_checker
	import kufe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [NODE_W-1:0]   cfg_wdata,
	input  logic                start,
	input  logic                busy,
	input  logic                cmd,
	input  logic [NODE_W-1:0]   node_a,
	input  logic [NODE_W-1:0]   node_b,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic                done,
	input  logic                accepted,
	input  logic [SUM_W-1:0]    total_weight,
	input  logic [COUNT_W-1:0]  component_count,
	input  logic                all_joined,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               joined;
		logic [SUM_W-1:0]   total;
		logic [COUNT_W-1:0] count;
		logic               single;
	} tree_report_t;

	tree_report_t reports_due[$];

	// Own copy of the disjoint-set forest and the node-count register.
	logic [NODE_W-1:0] nodes_in_use;
	logic [IDX_W-1:0]  up_link [TABLE_DEPTH];
	logic [SIZE_W-1:0] set_size [TABLE_DEPTH];
	logic [SETS_W-1:0] groups_left;
	logic [SUM_W-1:0]  tree_weight;
	int                err_total = 0;

	function automatic void wipe_forest();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			up_link[i]  = IDX_W'(i);
			set_size[i] = SIZE_W'(1);
		end
		groups_left = SETS_W'(nodes_in_use);
		tree_weight = '0;
	endfunction

	function automatic logic [IDX_W-1:0] find_root(input logic [IDX_W-1:0] from_node);
		logic [IDX_W-1:0] walk;
		walk = from_node;
		for (int s = 0; s < TABLE_DEPTH; s++) begin
			if (up_link[walk] == walk)
				break;
			walk = up_link[walk];
		end
		return walk;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			err_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [IDX_W-1:0] root_a, root_b;
		logic [SUM_W:0]   sum_wide;
		logic             joined;
		tree_report_t     want;
		if (!arst_n) begin
			reports_due.delete();
			nodes_in_use = NODE_W'(NODE_LIMIT);
			wipe_forest();
			outstanding <= 0;
			mismatches  <= err_total;
		end else begin
			if (cfg_we)
				nodes_in_use = cfg_wdata;
			if (done) begin
				if (reports_due.size() == 0) begin
					$display("%0t: report expected none actual one", $time);
					err_total++;
				end else begin
					want = reports_due.pop_front();
					compare_field("accepted", 32'(want.joined), 32'(accepted));
					compare_field("total_weight", 32'(want.total), 32'(total_weight));
					compare_field("component_count", 32'(want.count), 32'(component_count));
					compare_field("all_joined", 32'(want.single), 32'(all_joined));
				end
			end
			if (start && !busy) begin
				joined = 1'b0;
				if (cmd == CMD_CLEAR) begin
					wipe_forest();
				end else if (node_a >= 1 && node_a <= nodes_in_use && node_b >= 1 &&
						node_b <= nodes_in_use && groups_left > 1) begin
					root_a = find_root(node_a);
					root_b = find_root(node_b);
					if (root_a != root_b) begin
						// link the smaller set under the larger; a tie goes under b
						if (set_size[root_a] > set_size[root_b]) begin
							up_link[root_b]  = root_a;
							set_size[root_a] = set_size[root_a] + set_size[root_b];
						end else begin
							up_link[root_a]  = root_b;
							set_size[root_b] = set_size[root_b] + set_size[root_a];
						end
						if (groups_left > 0)
							groups_left = groups_left - SETS_W'(1);
						sum_wide    = {1'b0, tree_weight} + (SUM_W + 1)'(weight);
						tree_weight = (sum_wide > SUM_MAX) ? SUM_MAX : sum_wide[SUM_W-1:0];
						joined      = 1'b1;
					end
				end
				want.joined = joined;
				want.total  = tree_weight;
				want.count  = (groups_left > COUNT_MAX) ? COUNT_MAX : groups_left[COUNT_W-1:0];
				want.single = (groups_left == 1);
				reports_due.push_back(want);
			end
			outstanding <= reports_due.size();
			mismatches  <= err_total;
		end
	end

endmodule

@@ verif/tb_top.sv @@
// Testbench top: drives edge and clear items and node-count writes, and gives the verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kufe_pkg::*;

	// About 600 random items after the directed ones; the tail runs with no idling.
	localparam int RANDOM_ITEMS = 600;
	localparam int QUIET_TAIL   = 100;
	// Cycle budget: several times the slowest correct run, in which every item is a clear,
	// plus the longest gap and the drain around each node-count write.
	localparam int CYCLE_LIMIT  = 2000000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [NODE_W-1:0]   cfg_wdata;
	logic                start;
	logic                busy;
	logic                cmd;
	logic [NODE_W-1:0]   node_a;
	logic [NODE_W-1:0]   node_b;
	logic [WEIGHT_W-1:0] weight;
	logic                done;
	logic                accepted;
	logic [SUM_W-1:0]    total_weight;
	logic [COUNT_W-1:0]  component_count;
	logic                all_joined;
	int                  mismatches;
	int                  outstanding;
	int                  cycle_count = 0;

	always #4 clk = ~clk;

	kruskal_union_find_engine_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.node_a          (node_a),
		.node_b          (node_b),
		.weight          (weight),
		.done            (done),
		.accepted        (accepted),
		.total_weight    (total_weight),
		.component_count (component_count),
		.all_joined      (all_joined)
	);

	kufe_result_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.node_a          (node_a),
		.node_b          (node_b),
		.weight          (weight),
		.done            (done),
		.accepted        (accepted),
		.total_weight    (total_weight),
		.component_count (component_count),
		.all_joined      (all_joined),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	// Guard against a hung handshake: stop the run once the cycle budget is spent.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one item and hold it until the engine takes it; start is left high so that
	// a following item can go out on the very next edge.
	task automatic issue(input logic op, input int a, input int b, input int w);
		start  <= 1'b1;
		cmd    <= op;
		node_a <= NODE_W'(a);
		node_b <= NODE_W'(b);
		weight <= WEIGHT_W'(w);
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every expected report is in and the engine is idle.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	// Hold the sender off for a burst of cycles.
	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Write the node-count register only while idle: drain first, then one write cycle.
	task automatic set_nodes_used(input int value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= NODE_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int sent, sel, nodes_now, edge_total, kind, a, b, w, step;
		bit idling, refresh;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		start     = 1'b0;
		cmd       = CMD_CLEAR;
		node_a    = '0;
		node_b    = '0;
		weight    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// The reset pass sweeps the tables with busy high and reports nothing.
		settle();

		// Directed part, node count at its reset value of 511.
		issue(CMD_EDGE, 0, 1, 100);        // node zero is never in range
		issue(CMD_EDGE, 1, 511, 0);        // both range ends, lowest weight
		issue(CMD_EDGE, 511, 1, 65535);    // same set now, highest weight
		issue(CMD_EDGE, 5, 5, 7);          // self loop
		issue(CMD_EDGE, 2, 0, 8);          // second endpoint zero
		issue(CMD_CLEAR, 511, 511, 65535); // clear ignores the other fields

		// Shrink the range without a clear: the count still comes from 511.
		set_nodes_used(3);
		issue(CMD_EDGE, 1, 4, 1);          // above the new range
		issue(CMD_EDGE, 1, 2, 10);
		issue(CMD_CLEAR, 0, 0, 0);
		issue(CMD_EDGE, 1, 2, 5);
		issue(CMD_EDGE, 2, 3, 7);          // all joined
		issue(CMD_EDGE, 1, 3, 9);          // rejected once joined
		issue(CMD_EDGE, 3, 1, 9);

		// No node in range at all.
		set_nodes_used(0);
		issue(CMD_CLEAR, 0, 0, 0);
		issue(CMD_EDGE, 1, 1, 3);
		issue(CMD_EDGE, 1, 2, 3);

		// A single node is one set from the start.
		set_nodes_used(1);
		issue(CMD_CLEAR, 0, 0, 0);
		issue(CMD_EDGE, 1, 1, 4);

		// Widen the range without a clear: one set left, so still rejected.
		set_nodes_used(2);
		issue(CMD_EDGE, 1, 2, 6);
		issue(CMD_CLEAR, 0, 0, 0);
		issue(CMD_EDGE, 2, 1, 65535);

		// Random part: mostly well-formed runs of ascending edges after a clear, with
		// some noise, out-of-range nodes, stray clears and broken weight order.
		sent      = 0;
		nodes_now = 2;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				nodes_now = $urandom_range(0, 1);
			else if (sel == 1)
				nodes_now = 511;
			else if (sel <= 4)
				nodes_now = $urandom_range(17, 80);
			else
				nodes_now = $urandom_range(2, 16);
			refresh = ($urandom_range(0, 5) != 0);
			// The drain inside the write is the sender's pause for every report.
			set_nodes_used(nodes_now);
			if (refresh) begin
				issue(CMD_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511),
					$urandom_range(0, 65535));
				sent++;
			end
			if (nodes_now <= 1)
				edge_total = $urandom_range(2, 6);
			else if (nodes_now == 511)
				edge_total = $urandom_range(20, 60);
			else if (nodes_now > 16)
				edge_total = $urandom_range(nodes_now, 2 * nodes_now);
			else
				edge_total = $urandom_range(nodes_now, 3 * nodes_now + 2);
			w      = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
			idling = ($urandom_range(0, 2) != 0);
			for (int e = 0; e < edge_total && sent < RANDOM_ITEMS; e++) begin
				if (idling && sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
					hold_off($urandom_range(1, 14));
				step = $urandom_range(0, 400);
				w    = (w + step > 65535) ? 65535 : w + step;
				if (nodes_now == 0) begin
					a = $urandom_range(0, 511);
					b = $urandom_range(0, 511);
				end else begin
					a = $urandom_range(1, nodes_now);
					b = $urandom_range(1, nodes_now);
				end
				kind = $urandom_range(0, 29);
				if (kind <= 2) begin
					a = $urandom_range(0, 511);
					b = $urandom_range(0, 511);
				end else if (kind <= 4) begin
					// push one endpoint out of range: zero or above the node count
					if (nodes_now == 511 || $urandom_range(0, 2) == 0)
						a = 0;
					else
						a = $urandom_range(nodes_now + 1, 511);
					if ($urandom_range(0, 1)) begin
						step = a;
						a    = b;
						b    = step;
					end
				end else if (kind == 6) begin
					w = $urandom_range(0, 65535);
				end
				if (kind == 5)
					issue(CMD_CLEAR, a, b, w);
				else
					issue(CMD_EDGE, a, b, w);
				sent++;
			end
		end

		// Let the last reports arrive, then allow for the longest edge latency.
		settle();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
